[src/aarm_pkg.sv]
package aarm_pkg;

    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] m_r0_c0;
        logic signed [15:0] m_r0_c1;
        logic signed [15:0] m_r0_c2;
        logic signed [15:0] m_r1_c0;
        logic signed [15:0] m_r1_c1;
        logic signed [15:0] m_r1_c2;
        logic signed [15:0] m_r2_c0;
        logic signed [15:0] m_r2_c1;
        logic signed [15:0] m_r2_c2;
    } mat_t;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
    localparam logic [11:0]        THR_RESET = 12'd20;

    // pipeline depths of the sections
    localparam int NORM_LAT = 17;
    localparam int AXIS_LAT = 15;
    localparam int TRIG_LAT = 23;
    localparam int COMP_LAT = 3;
    localparam int TOTAL_LAT = NORM_LAT + TRIG_LAT + COMP_LAT;

    // series divisors, innermost term first
    localparam int SIN_DIV [5] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

endpackage

[src/axis_angle_to_rotation_matrix.sv]
// Rotation vector (Q4.12 per component) in, 3x3 rotation matrix (Q1.14, saturated to +-1) out,
// one beat per clock while not stalled, through three sections: the squared norm and the
// bit-per-stage square root, then the phase, quarter-wave series and quadrant fold (the axis
// divide runs alongside), and last forming and rounding the matrix entries. A zero vector gives
// the identity and angles below the threshold register use the first-order form. When the
// result beat is held by stall the whole pipeline freezes and the input side stalls with it.
// The threshold is written through thr_wr_en/thr_wr_data and resets to 20.
module axis_angle_to_rotation_matrix
    import aarm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vec_valid,
    output logic        vec_stall,
    input  vec_t        vec,
    output logic        mat_valid,
    input  logic        mat_stall,
    output mat_t        mat,
    input  logic        thr_wr_en,
    input  logic [11:0] thr_wr_data
);

    logic [11:0]          thr_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 en;

    logic [15:0]        angle;
    vec_t               vec_n, vec_d;
    logic               zero_n, zero_d, small_n, small_d;
    logic signed [15:0] axis_a [3];
    logic signed [15:0] axis_d [3];
    logic signed [15:0] sin_q, cos_q;

    assign en        = !(vld_reg[TOTAL_LAT-1] && mat_stall);
    assign vec_stall = !en;
    assign mat_valid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (thr_wr_en)
            begin
                thr_reg <= thr_wr_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[TOTAL_LAT-2:0], vec_valid};
            end
        end
    end

    aarm_norm u_norm (
        .clk(clk), .en(en), .vec(vec), .angle(angle), .vec_out(vec_n), .zero(zero_n)
    );

    assign small_n = angle < {4'd0, thr_reg};

    aarm_axis u_axis (
        .clk(clk), .en(en), .angle(angle), .vec(vec_n), .axis(axis_a)
    );

    aarm_delay #(.WIDTH(48), .DEPTH(TRIG_LAT - AXIS_LAT)) u_axis_dly (
        .clk  (clk),
        .en   (en),
        .din  ({axis_a[0], axis_a[1], axis_a[2]}),
        .dout ({axis_d[0], axis_d[1], axis_d[2]})
    );

    aarm_trig u_trig (
        .clk(clk), .en(en), .angle(angle), .sin_q(sin_q), .cos_q(cos_q)
    );

    aarm_delay #(.WIDTH($bits(vec_t) + 2), .DEPTH(TRIG_LAT)) u_side_dly (
        .clk  (clk),
        .en   (en),
        .din  ({vec_n, zero_n, small_n}),
        .dout ({vec_d, zero_d, small_d})
    );

    aarm_compose u_compose (
        .clk         (clk),
        .en          (en),
        .axis        (axis_d),
        .sin_q       (sin_q),
        .cos_q       (cos_q),
        .vec         (vec_d),
        .zero        (zero_d),
        .first_order (small_d),
        .mat         (mat)
    );

endmodule

[src/aarm_delay.sv]
module aarm_delay
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

[src/aarm_norm.sv]
module aarm_norm
    import aarm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  vec_t        vec,
    output logic [15:0] angle,
    output vec_t        vec_out,
    output logic        zero
);

    localparam int ROOT_W = 16;

    logic signed [31:0] px, py, pz;
    logic [31:0]        sq_reg;
    vec_t               vec_reg;

    logic [31:0] rem_in   [ROOT_W];
    logic [15:0] root_in  [ROOT_W];
    logic [33:0] trial    [ROOT_W];
    logic [31:0] rem_next [ROOT_W];
    logic [15:0] root_next[ROOT_W];
    logic [31:0] rem_reg  [ROOT_W];
    logic [15:0] root_reg [ROOT_W];

    assign px = vec.rot_x * vec.rot_x;
    assign py = vec.rot_y * vec.rot_y;
    assign pz = vec.rot_z * vec.rot_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= unsigned'(px) + unsigned'(py) + unsigned'(pz);
            vec_reg <= vec;
        end
    end

    // one root bit per stage, remainder kept as n - root^2
    always_comb
    begin
        rem_in[0]  = sq_reg;
        root_in[0] = '0;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial[k] = (34'(root_in[k]) << (ROOT_W - k)) | (34'd1 << (2 * (ROOT_W - 1 - k)));
            if ({2'b00, rem_in[k]} >= trial[k])
            begin
                rem_next[k]  = rem_in[k] - trial[k][31:0];
                root_next[k] = root_in[k] | (16'd1 << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    aarm_delay #(.WIDTH($bits(vec_t) + 1), .DEPTH(ROOT_W)) u_side (
        .clk  (clk),
        .en   (en),
        .din  ({vec_reg, sq_reg == 32'd0}),
        .dout ({vec_out, zero})
    );

    assign angle = root_reg[ROOT_W-1];

endmodule

[src/aarm_axis.sv]
module aarm_axis
    import aarm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    input  vec_t               vec,
    output logic signed [15:0] axis [3]
);

    localparam int QW = 15;

    logic signed [15:0] comp [3];
    logic [15:0]        mag  [3];
    logic [15:0]        dvs_in   [QW];
    logic [15:0]        dvs_reg  [QW];
    logic [29:0]        rem_in   [3][QW];
    logic [14:0]        quo_in   [3][QW];
    logic [30:0]        shifted  [QW];
    logic [29:0]        rem_next [3][QW];
    logic [14:0]        quo_next [3][QW];
    logic [29:0]        rem_reg  [3][QW];
    logic [14:0]        quo_reg  [3][QW];
    logic [2:0]         neg;
    logic [14:0]        qc [3];

    assign comp[0] = vec.rot_x;
    assign comp[1] = vec.rot_y;
    assign comp[2] = vec.rot_z;

    // restoring division of (|r| << 14) + a/2 by a, one quotient bit per stage
    always_comb
    begin
        dvs_in[0] = angle;
        for (int k = 1; k < QW; k++)
        begin
            dvs_in[k] = dvs_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            shifted[k] = 31'(dvs_in[k]) << (QW - 1 - k);
        end
        for (int l = 0; l < 3; l++)
        begin
            mag[l]       = comp[l][15] ? (~comp[l] + 16'd1) : comp[l];
            rem_in[l][0] = {mag[l], 14'd0} + 30'(angle >> 1);
            quo_in[l][0] = '0;
            for (int k = 1; k < QW; k++)
            begin
                rem_in[l][k] = rem_reg[l][k-1];
                quo_in[l][k] = quo_reg[l][k-1];
            end
            for (int k = 0; k < QW; k++)
            begin
                if ({1'b0, rem_in[l][k]} >= shifted[k])
                begin
                    rem_next[l][k] = rem_in[l][k] - shifted[k][29:0];
                    quo_next[l][k] = quo_in[l][k] | (15'd1 << (QW - 1 - k));
                end
                else
                begin
                    rem_next[l][k] = rem_in[l][k];
                    quo_next[l][k] = quo_in[l][k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                dvs_reg[k] <= dvs_in[k];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[l][k] <= rem_next[l][k];
                    quo_reg[l][k] <= quo_next[l][k];
                end
            end
        end
    end

    aarm_delay #(.WIDTH(3), .DEPTH(QW)) u_sign (
        .clk  (clk),
        .en   (en),
        .din  ({comp[0][15], comp[1][15], comp[2][15]}),
        .dout (neg)
    );

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qc[l]   = (quo_reg[l][QW-1] > 15'd16384) ? 15'd16384 : quo_reg[l][QW-1];
            axis[l] = neg[2-l] ? -$signed({1'b0, qc[l]}) : $signed({1'b0, qc[l]});
        end
    end

endmodule

[src/aarm_horner.sv]
module aarm_horner
    import aarm_pkg::*;
#(
    parameter int DIV = 2
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        t2,
    input  logic signed [31:0] h,
    output logic [31:0]        t2_out,
    output logic signed [31:0] h_out
);

    // floor(2^32/DIV): the estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [62:0]        prod;
    logic [31:0]        n_reg, n2_reg;
    logic [31:0]        t2a_reg, t2b_reg, t2c_reg;
    logic [63:0]        m_reg;
    logic [31:0]        q0, rem, quo;
    logic signed [31:0] h_reg;

    assign prod = 63'(t2) * 63'(h[30:0]);

    always_comb
    begin
        q0  = m_reg[63:32];
        rem = n2_reg - 32'(q0 * DIV);
        quo = (rem >= 32'(DIV)) ? q0 + 32'd1 : q0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= prod[61:30];
            t2a_reg <= t2;
            m_reg   <= 64'(n_reg) * 64'(RECIP);
            n2_reg  <= n_reg;
            t2b_reg <= t2a_reg;
            h_reg   <= Q30_ONE - signed'(quo);
            t2c_reg <= t2b_reg;
        end
    end

    assign t2_out = t2c_reg;
    assign h_out  = h_reg;

endmodule

[src/aarm_trig.sv]
module aarm_trig
    import aarm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [15:0] sin_q,
    output logic signed [15:0] cos_q
);

    localparam logic [37:0] TURN_SCALE  = 38'd174992710548;
    localparam logic [18:0] TURN_HI     = TURN_SCALE[37:19];
    localparam logic [18:0] TURN_LO     = TURN_SCALE[18:0];
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int          NSIN = 5;
    localparam int          NCOS = 6;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    logic [34:0] ph_hi_reg, ph_lo_reg;
    logic [53:0] ph;
    logic [1:0]  quad_reg, quad_d;
    logic [29:0] x_reg;
    logic [60:0] tx;
    logic [30:0] t_reg, t_d;
    logic [61:0] tt, ts;
    logic [31:0] t2_reg;
    logic [31:0] sv_reg, sv_d;

    logic [31:0]        s_t2 [NSIN];
    logic signed [31:0] s_h  [NSIN+1];
    logic [31:0]        c_t2 [NCOS];
    logic signed [31:0] c_h  [NCOS+1];

    logic [31:0]        sv_c;
    logic [30:0]        cv_c;
    logic [14:0]        s15, c15;
    logic signed [15:0] sp, cp, sin_next, cos_next;
    logic signed [15:0] sin_reg, cos_reg;

    assign ph = {ph_hi_reg, 19'd0} + 54'(ph_lo_reg);
    assign tx = 61'(x_reg) * 61'(HALF_PI_Q30);
    assign tt = 62'(t_reg) * 62'(t_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_hi_reg <= 35'(angle) * 35'(TURN_HI);
            ph_lo_reg <= 35'(angle) * 35'(TURN_LO);
            quad_reg  <= ph[51:50];
            x_reg     <= ph[49:20];
            t_reg     <= tx[60:30];
            t2_reg    <= tt[61:30];
        end
    end

    assign s_t2[0] = t2_reg;
    assign s_h[0]  = Q30_ONE;
    assign c_t2[0] = t2_reg;
    assign c_h[0]  = Q30_ONE;

    for (genvar g = 0; g < NSIN; g++)
    begin : g_sin
        if (g < NSIN - 1)
        begin : g_mid
            aarm_horner #(.DIV(SIN_DIV[g])) u_step (
                .clk(clk), .en(en), .t2(s_t2[g]), .h(s_h[g]),
                .t2_out(s_t2[g+1]), .h_out(s_h[g+1])
            );
        end
        else
        begin : g_last
            aarm_horner #(.DIV(SIN_DIV[g])) u_step (
                .clk(clk), .en(en), .t2(s_t2[g]), .h(s_h[g]),
                .t2_out(), .h_out(s_h[g+1])
            );
        end
    end

    for (genvar g = 0; g < NCOS; g++)
    begin : g_cos
        if (g < NCOS - 1)
        begin : g_mid
            aarm_horner #(.DIV(COS_DIV[g])) u_step (
                .clk(clk), .en(en), .t2(c_t2[g]), .h(c_h[g]),
                .t2_out(c_t2[g+1]), .h_out(c_h[g+1])
            );
        end
        else
        begin : g_last
            aarm_horner #(.DIV(COS_DIV[g])) u_step (
                .clk(clk), .en(en), .t2(c_t2[g]), .h(c_h[g]),
                .t2_out(), .h_out(c_h[g+1])
            );
        end
    end

    // t lines up with the last sine step
    aarm_delay #(.WIDTH(31), .DEPTH(3 * NSIN + 1)) u_t (
        .clk(clk), .en(en), .din(t_reg), .dout(t_d)
    );

    assign ts = 62'(t_d) * 62'(s_h[NSIN][30:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg <= ts[61:30];
        end
    end

    aarm_delay #(.WIDTH(32), .DEPTH(3 * (NCOS - NSIN) - 1)) u_sv (
        .clk(clk), .en(en), .din(sv_reg), .dout(sv_d)
    );

    aarm_delay #(.WIDTH(2), .DEPTH(3 * NCOS + 2)) u_quad (
        .clk(clk), .en(en), .din(quad_reg), .dout(quad_d)
    );

    always_comb
    begin
        sv_c = (sv_d > 32'(Q30_ONE)) ? 32'(Q30_ONE) : sv_d;
        if (c_h[NCOS] < 0)
        begin
            cv_c = '0;
        end
        else if (c_h[NCOS] > Q30_ONE)
        begin
            cv_c = 31'(Q30_ONE);
        end
        else
        begin
            cv_c = c_h[NCOS][30:0];
        end
        s15 = 15'((33'(sv_c) + 33'd32768) >> 16);
        c15 = 15'((32'(cv_c) + 32'd32768) >> 16);
        sp  = $signed({1'b0, s15});
        cp  = $signed({1'b0, c15});
        case (quad_d)
            QUAD_I:
            begin
                sin_next = sp;
                cos_next = cp;
            end
            QUAD_II:
            begin
                sin_next = cp;
                cos_next = -sp;
            end
            QUAD_III:
            begin
                sin_next = -sp;
                cos_next = -cp;
            end
            default:
            begin
                sin_next = -cp;
                cos_next = sp;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

[src/aarm_compose.sv]
module aarm_compose
    import aarm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] axis [3],
    input  logic signed [15:0] sin_q,
    input  logic signed [15:0] cos_q,
    input  vec_t               vec,
    input  logic               zero,
    input  logic               first_order,
    output mat_t               mat
);

    logic signed [31:0] uu   [3][3];
    logic signed [15:0] p_reg [3][3];
    logic signed [15:0] s1_reg, c1_reg;
    vec_t               vec1_reg, vec2_reg;
    logic               zero1_reg, zero2_reg, small1_reg, small2_reg;
    // axis components lined up with p_reg
    logic signed [15:0] u1_reg [3];

    logic signed [16:0] omc;
    logic signed [33:0] su   [3];
    logic signed [33:0] ks   [3][3];
    logic signed [33:0] op   [3][3];
    logic signed [33:0] diag;
    logic signed [33:0] acc_next [3][3];
    logic signed [33:0] acc_reg  [3][3];

    logic signed [15:0] m  [3][3];
    logic signed [15:0] sx, sy, sz;
    mat_t               mat_next, mat_reg;

    function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
        if (v > 34'sd16384)
        begin
            return Q14_ONE;
        end
        else if (v < -34'sd16384)
        begin
            return -Q14_ONE;
        end
        return v[15:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                uu[i][j] = axis[i] * axis[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[i][j] <= 16'((uu[i][j] + 32'sd8192) >>> 14);
                end
            end
            s1_reg     <= sin_q;
            c1_reg     <= cos_q;
            vec1_reg   <= vec;
            zero1_reg  <= zero;
            small1_reg <= first_order;
        end
    end

    // acc = c*I - s*K + (1-c)*uu^T in Q.28; the -s*K terms reuse s*u
    always_comb
    begin
        omc  = 17'sd16384 - 17'(c1_reg);
        diag = 34'(c1_reg) <<< 14;
        for (int i = 0; i < 3; i++)
        begin
            su[i] = s1_reg * u1_reg[i];
        end
        ks[0][0] = '0;
        ks[0][1] = su[2];
        ks[0][2] = -su[1];
        ks[1][0] = -su[2];
        ks[1][1] = '0;
        ks[1][2] = su[0];
        ks[2][0] = su[1];
        ks[2][1] = -su[0];
        ks[2][2] = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                op[i][j]       = omc * p_reg[i][j];
                acc_next[i][j] = ks[i][j] + op[i][j] + ((i == j) ? diag : 34'sd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg    <= acc_next;
            vec2_reg   <= vec1_reg;
            zero2_reg  <= zero1_reg;
            small2_reg <= small1_reg;
        end
    end

    always_comb
    begin
        sx = clamp_q14(34'(vec2_reg.rot_x) <<< 2);
        sy = clamp_q14(34'(vec2_reg.rot_y) <<< 2);
        sz = clamp_q14(34'(vec2_reg.rot_z) <<< 2);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (zero2_reg)
                begin
                    m[i][j] = (i == j) ? Q14_ONE : 16'sd0;
                end
                else
                begin
                    m[i][j] = clamp_q14((acc_reg[i][j] + 34'sd8192) >>> 14);
                end
            end
        end
        if (!zero2_reg && small2_reg)
        begin
            m[0][0] = Q14_ONE;
            m[0][1] = sz;
            m[0][2] = -sy;
            m[1][0] = -sz;
            m[1][1] = Q14_ONE;
            m[1][2] = sx;
            m[2][0] = sy;
            m[2][1] = -sx;
            m[2][2] = Q14_ONE;
        end
        mat_next.m_r0_c0 = m[0][0];
        mat_next.m_r0_c1 = m[0][1];
        mat_next.m_r0_c2 = m[0][2];
        mat_next.m_r1_c0 = m[1][0];
        mat_next.m_r1_c1 = m[1][1];
        mat_next.m_r1_c2 = m[1][2];
        mat_next.m_r2_c0 = m[2][0];
        mat_next.m_r2_c1 = m[2][1];
        mat_next.m_r2_c2 = m[2][2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u1_reg[i] <= axis[i];
            end
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule
